[hw/rtl/lrg_pkg.sv]
// Shared types, constants and cell-update functions for the Life row generation step unit.
`default_nettype none

package lrg_pkg;

  // Grid geometry.
  localparam int ROW_CELLS = 64;
  localparam int MAX_ROWS  = 1024;

  // Field widths.
  localparam int WIDTH_W = 7;
  localparam int CNT_W   = $clog2(MAX_ROWS + 1);
  localparam int IDX_W   = 10;

  // Highest row index that can be reported.
  localparam int IDX_TOP = (MAX_ROWS - 1 < 1023) ? (MAX_ROWS - 1) : 1023;

  // Row width after reset.
  localparam int WIDTH_RESET = 64;

  // Job queue between the front and the back end.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef logic [ROW_CELLS-1:0] row_t;
  typedef logic [WIDTH_W-1:0]   width_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [QPTR_W-1:0]    qptr_t;
  typedef logic [QCNT_W-1:0]    qcnt_t;

  // One accepted request that produces at least one result.
  typedef struct packed {
    row_t upper;     // row two above the incoming one
    row_t middle;    // row just above the incoming one
    row_t row;       // incoming row, already masked
    cnt_t rows_seen; // rows taken in the frame before this one
    logic has_prev;  // a result for the row above is due
    logic last;      // incoming row closes the frame
  } lrg_job_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } lrg_qstat_t;

  // Mask of the cells in use for a given width.
  function automatic row_t used_mask(width_t w);
    row_t m;
    for (int j = 0; j < ROW_CELLS; j++) begin
      m[j] = ({1'b0, w} > 8'(j));
    end
    return m;
  endfunction

  // B3/S23 update of the middle row; cells outside the row are dead.
  function automatic row_t next_gen(row_t a, row_t m, row_t b);
    logic [ROW_CELLS+1:0] pa;
    logic [ROW_CELLS+1:0] pm;
    logic [ROW_CELLS+1:0] pb;
    logic [3:0]           cnt;
    row_t                 res;
    pa = {1'b0, a, 1'b0};
    pm = {1'b0, m, 1'b0};
    pb = {1'b0, b, 1'b0};
    for (int j = 0; j < ROW_CELLS; j++) begin
      cnt = {3'b000, pa[j]} + {3'b000, pa[j+1]} + {3'b000, pa[j+2]}
          + {3'b000, pm[j]} + {3'b000, pm[j+2]}
          + {3'b000, pb[j]} + {3'b000, pb[j+1]} + {3'b000, pb[j+2]};
      res[j] = (cnt == 4'd3) || (m[j] && (cnt == 4'd2));
    end
    return res;
  endfunction

  // Saturating conversion of a row count to a reported index.
  function automatic idx_t index_of(cnt_t c);
    if (c > cnt_t'(IDX_TOP)) begin
      return idx_t'(IDX_TOP);
    end
    return c[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/lrg_ifs.sv]
// Channel interfaces for row requests, result rows and the row width register.
`default_nettype none

interface lrg_in_if;
  import lrg_pkg::*;
  logic valid;
  logic ready;
  row_t row_cells;
  logic last_row;
  modport source (output valid, output row_cells, output last_row, input ready);
  modport sink (input valid, input row_cells, input last_row, output ready);
endinterface

interface lrg_out_if;
  import lrg_pkg::*;
  logic valid;
  logic ready;
  idx_t row_index;
  row_t new_row;
  row_t changed_mask;
  logic last_of_frame;
  modport source (output valid, output row_index, output new_row, output changed_mask,
                  output last_of_frame, input ready);
  modport sink (input valid, input row_index, input new_row, input changed_mask,
                input last_of_frame, output ready);
endinterface

interface lrg_cfg_if;
  import lrg_pkg::*;
  logic   valid;
  logic   ready;
  width_t row_width;
  modport source (output valid, output row_width, input ready);
  modport sink (input valid, input row_width, output ready);
endinterface

`default_nettype wire

[hw/rtl/lrg_front.sv]
// Front end: accepts rows, keeps the two-row window and queues result jobs.
`default_nettype none

module lrg_front (
  input  logic                clk,
  input  logic                rst_n,
  lrg_in_if.sink              in_chan,
  input  lrg_pkg::row_t       mask,
  input  lrg_pkg::lrg_qstat_t qstat,
  output logic                push,
  output lrg_pkg::lrg_job_t   push_job
);
  import lrg_pkg::*;

  row_t upper_r, upper_nxt;
  row_t middle_r, middle_nxt;
  cnt_t cnt_r, cnt_nxt;
  row_t row_m;
  logic accept;

  assign in_chan.ready = !qstat.full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign row_m         = in_chan.row_cells & mask;

  // A first row that is not also the last one only fills the window.
  assign push = accept && ((cnt_r != '0) || in_chan.last_row);

  always_comb begin
    push_job.upper     = upper_r;
    push_job.middle    = middle_r;
    push_job.row       = row_m;
    push_job.rows_seen = cnt_r;
    push_job.has_prev  = (cnt_r != '0);
    push_job.last      = in_chan.last_row;
  end

  always_comb begin
    upper_nxt  = upper_r;
    middle_nxt = middle_r;
    cnt_nxt    = cnt_r;
    if (accept) begin
      if (in_chan.last_row) begin
        upper_nxt  = '0;
        middle_nxt = '0;
        cnt_nxt    = '0;
      end else begin
        upper_nxt  = middle_r;
        middle_nxt = row_m;
        if (cnt_r < cnt_t'(MAX_ROWS)) begin
          cnt_nxt = cnt_r + cnt_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r  <= '0;
      middle_r <= '0;
      cnt_r    <= '0;
    end else begin
      upper_r  <= upper_nxt;
      middle_r <= middle_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // The row counter saturates and never runs past the frame limit.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(MAX_ROWS))
    else $error("row counter beyond limit");

endmodule

`default_nettype wire

[hw/rtl/lrg_queue.sv]
// Short job queue that decouples the front end from the back end.
`default_nettype none

module lrg_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lrg_pkg::lrg_job_t    push_job,
  input  logic                 pop,
  output lrg_pkg::lrg_job_t    head_job,
  output lrg_pkg::lrg_qstat_t  qstat
);
  import lrg_pkg::*;

  lrg_job_t slot_r [QDEPTH];
  qptr_t    wr_ptr_r, wr_ptr_nxt;
  qptr_t    rd_ptr_r, rd_ptr_nxt;
  qcnt_t    count_r, count_nxt;

  assign qstat.full  = (count_r == qcnt_t'(QDEPTH));
  assign qstat.empty = (count_r == '0);
  assign head_job    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + qptr_t'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + qptr_t'(1) : rd_ptr_r;
    count_nxt  = count_r + qcnt_t'(push) - qcnt_t'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("push into a full job queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("pop from an empty job queue");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == qcnt_t'(QDEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

[hw/rtl/lrg_back.sv]
// Back end: evaluates the next generation of a row and holds it in the output register.
`default_nettype none

module lrg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lrg_pkg::lrg_job_t   head_job,
  input  lrg_pkg::lrg_qstat_t qstat,
  input  lrg_pkg::row_t       mask,
  output logic                pop,
  lrg_out_if.source           out_chan
);
  import lrg_pkg::*;

  logic phase_r, phase_nxt;
  logic out_valid_r, out_valid_nxt;
  idx_t idx_r;
  row_t new_row_r;
  row_t changed_r;
  logic last_r;

  logic fire;
  logic second;
  row_t sel_above, sel_mid, sel_below;
  row_t nr;
  idx_t idx_sel;

  // The second result of a job describes the last row with a dead row below it.
  assign second = !head_job.has_prev || phase_r;
  assign fire   = !qstat.empty && (!out_valid_r || out_chan.ready);
  assign pop    = fire && (second || !head_job.last);

  always_comb begin
    sel_above = second ? head_job.middle : head_job.upper;
    sel_mid   = second ? head_job.row : head_job.middle;
    sel_below = second ? '0 : head_job.row;
    idx_sel   = second ? index_of(head_job.rows_seen)
                       : index_of(head_job.rows_seen - cnt_t'(1));
    nr        = next_gen(sel_above, sel_mid, sel_below) & mask;
  end

  always_comb begin
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    if (fire) begin
      phase_nxt     = !second && head_job.last;
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      idx_r     <= idx_sel;
      new_row_r <= nr;
      changed_r <= (nr ^ sel_mid) & mask;
      last_r    <= second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.row_index     = idx_r;
  assign out_chan.new_row       = new_row_r;
  assign out_chan.changed_mask  = changed_r;
  assign out_chan.last_of_frame = last_r;

  // The second half of a two-result job always has its job still at the queue head.
  a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (!qstat.empty && head_job.last && head_job.has_prev))
    else $error("second result pending without its job");

endmodule

`default_nettype wire

[hw/rtl/life_row_generation_step_unit.sv]
// Top level of the streamed Life (B3/S23) row generation step unit.
`default_nettype none

// One generation of Conway's Life, birth on three and survival on two or three live
// neighbors, with every cell outside the grid dead. A frame is streamed one row per
// request on in_chan, bit j being cell j; last_row marks its final row. The result for
// a row leaves on out_chan once the row below it has arrived, and the final row also
// yields its own result with last_of_frame set, so a frame of N rows gives N results
// with row_index counting from zero and saturating at 1023. changed_mask flags the
// cells that were born or died. The row width register on cfg_chan (reset 64) limits
// the cells in use; cells at and above it read as dead and come out as zero. Write it
// only while no frame is in flight; it is always ready. The block takes one request per
// cycle while the job queue is not full: the front end keeps the two rows above the
// incoming one and places a job in a two-entry queue, and the back end evaluates all
// cells of a row combinationally into the output register. The last row of a frame,
// unless it is also the first, gives two results in turn through the single evaluation
// unit; a first row that is not the last produces nothing and only fills the window.
// A request's first result is held in the job queue, then in the output register.
module life_row_generation_step_unit (
  input  logic       clk,
  input  logic       rst_n,
  lrg_in_if.sink     in_chan,
  lrg_out_if.source  out_chan,
  lrg_cfg_if.sink    cfg_chan
);
  import lrg_pkg::*;

  width_t     width_r;
  row_t       mask;
  logic       push;
  logic       pop;
  lrg_job_t   push_job;
  lrg_job_t   head_job;
  lrg_qstat_t qstat;

  // The width register accepts a write in every cycle.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= width_t'(WIDTH_RESET);
    end else if (cfg_chan.valid) begin
      width_r <= cfg_chan.row_width;
    end
  end

  // Used-cell mask shared by both ends; widths past the row act as a full row.
  assign mask = used_mask(width_r);

  lrg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .mask     (mask),
    .qstat    (qstat),
    .push     (push),
    .push_job (push_job)
  );

  lrg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .qstat    (qstat)
  );

  lrg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .qstat    (qstat),
    .mask     (mask),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
